// ===== design/stramp_pkg.sv =====
// ----------------------------------------------------------------------------
// stramp_pkg
// Shared types, codes and defaults of the trapezoidal stepper ramp generator.
// ----------------------------------------------------------------------------
package stramp_pkg;

    localparam int TABLE_DEPTH   = 128;
    localparam int POSITION_BITS = 24;

    localparam int IVL_W     = 16;
    localparam int CFG_W     = 8;
    localparam int POS_OUT_W = 24;
    localparam int TARGET_W  = 16;
    localparam int PROD_W    = TARGET_W + CFG_W + 1;
    localparam int DIV_STEPS = IVL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] ACT_MOVE = 2'd0;
    localparam logic [1:0] ACT_STEP = 2'd1;
    localparam logic [1:0] ACT_ZERO = 2'd2;
    localparam logic [1:0] ACT_NOP  = 2'd3;

    localparam logic [1:0] REG_START_INTERVAL = 2'd0;
    localparam logic [1:0] REG_MIN_INTERVAL   = 2'd1;
    localparam logic [1:0] REG_RAMP_DIVISOR   = 2'd2;
    localparam logic [1:0] REG_UNITS_SCALE    = 2'd3;

    localparam logic [IVL_W-1:0] START_INTERVAL_RST = 16'd1000;
    localparam logic [CFG_W-1:0] MIN_INTERVAL_RST   = 8'd40;
    localparam logic [CFG_W-1:0] RAMP_DIVISOR_RST   = 8'd20;
    localparam logic [CFG_W-1:0] UNITS_SCALE_RST    = 8'd12;

    typedef struct packed {
        logic [1:0]                 action;
        logic signed [TARGET_W-1:0] target;
    } in_beat_t;

    typedef struct packed {
        logic                        step;
        logic                        direction;
        logic [IVL_W-1:0]            interval;
        logic signed [POS_OUT_W-1:0] position;
        logic                        busy_res;
        logic                        last_step;
    } out_beat_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ACCEL,
        PH_CRUISE,
        PH_DECEL
    } phase_t;

    typedef enum logic [2:0] {
        K_MOVE,
        K_ZERO,
        K_NOP,
        K_DECEL,
        K_ACCEL,
        K_CRUISE
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIFF,
        ST_DIV,
        ST_RDWAIT,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic diff;
        logic div_step;
        logic commit;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  div_needed;
        logic  div_last;
        logic  out_free;
    } dp_status_t;

endpackage

// ===== design/stramp_ram.sv =====
// ----------------------------------------------------------------------------
// stramp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stramp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/stramp_ctrl.sv =====
// ----------------------------------------------------------------------------
// stramp_ctrl
// Sequencer: decode, optional target difference, divider iterations, table
// read, state commit and hand-off to the output register.
// ----------------------------------------------------------------------------
module stramp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  stramp_pkg::dp_status_t status,
    output stramp_pkg::ctrl_cmd_t  cmd
);

    stramp_pkg::state_t state_reg;
    stramp_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stramp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stramp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = stramp_pkg::ST_DECODE;
                end
            end
            stramp_pkg::ST_DECODE: begin
                if (status.kind == stramp_pkg::K_MOVE) begin
                    state_next = stramp_pkg::ST_DIFF;
                end else if (status.kind == stramp_pkg::K_ACCEL && status.div_needed) begin
                    state_next = stramp_pkg::ST_DIV;
                end else if (status.kind == stramp_pkg::K_DECEL) begin
                    state_next = stramp_pkg::ST_RDWAIT;
                end else begin
                    state_next = stramp_pkg::ST_COMMIT;
                end
            end
            stramp_pkg::ST_DIFF:   state_next = stramp_pkg::ST_COMMIT;
            stramp_pkg::ST_DIV: begin
                if (status.div_last) begin
                    state_next = stramp_pkg::ST_COMMIT;
                end
            end
            stramp_pkg::ST_RDWAIT: state_next = stramp_pkg::ST_COMMIT;
            stramp_pkg::ST_COMMIT: state_next = stramp_pkg::ST_EMIT;
            stramp_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    state_next = stramp_pkg::ST_IDLE;
                end
            end
            default: state_next = stramp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            stramp_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            stramp_pkg::ST_DECODE: cmd.decode   = 1'b1;
            stramp_pkg::ST_DIFF:   cmd.diff     = 1'b1;
            stramp_pkg::ST_DIV:    cmd.div_step = 1'b1;
            stramp_pkg::ST_RDWAIT: cmd          = '0;
            stramp_pkg::ST_COMMIT: cmd.commit   = 1'b1;
            stramp_pkg::ST_EMIT:   cmd.emit     = status.out_free;
            default:               cmd          = '0;
        endcase
    end

endmodule

// ===== design/stramp_dp.sv =====
// ----------------------------------------------------------------------------
// stramp_dp
// Datapath: configuration registers, move state, target scaling, restoring
// divider for the ramp slope, ramp table and output register.
// ----------------------------------------------------------------------------
module stramp_dp #(
    parameter int TABLE_DEPTH   = stramp_pkg::TABLE_DEPTH,
    parameter int POSITION_BITS = stramp_pkg::POSITION_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    input  stramp_pkg::in_beat_t   s_data,
    input  stramp_pkg::ctrl_cmd_t  cmd,
    output stramp_pkg::dp_status_t status,
    input  logic                   m_ready,
    output logic                   m_valid,
    output stramp_pkg::out_beat_t  m_data
);

    localparam int PB   = POSITION_BITS;
    localparam int RL_W = $clog2(TABLE_DEPTH + 1);
    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int IW   = stramp_pkg::IVL_W;
    localparam int CW   = stramp_pkg::CFG_W;
    localparam logic signed [32:0] SAT_HI = 33'((64'sd1 <<< (PB - 1)) - 64'sd1);
    localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;

    logic [IW-1:0] start_ivl_reg;
    logic [CW-1:0] min_ivl_reg;
    logic [CW-1:0] divisor_reg;
    logic [CW-1:0] scale_reg;

    logic [1:0]                              action_reg;
    logic signed [stramp_pkg::TARGET_W-1:0]  target_reg;
    logic signed [stramp_pkg::PROD_W-1:0]    product_reg;
    logic signed [PB:0]                      diff_reg;
    stramp_pkg::kind_t                       kind_reg;
    stramp_pkg::kind_t                       kind_next;

    logic [PB-1:0]      pos_reg,   pos_next;
    logic [IW-1:0]      cur_reg,   cur_next;
    logic [RL_W-1:0]    rl_reg,    rl_next;
    stramp_pkg::phase_t phase_reg, phase_next;
    logic [PB-1:0]      steps_reg, steps_next;
    logic               dir_reg,   dir_next;

    logic          res_step_reg, res_step_next;
    logic [IW-1:0] res_ivl_reg,  res_ivl_next;
    logic          res_last_reg, res_last_next;

    logic [IW-1:0]                        quo_reg;
    logic [CW-1:0]                        rem_reg;
    logic [stramp_pkg::DIV_CNT_W-1:0]     cnt_reg;

    logic                  m_valid_reg;
    stramp_pkg::out_beat_t m_data_reg;

    // decode
    logic [PB:0] rl_plus2;
    logic        div_needed;

    always_comb begin
        rl_plus2  = (PB + 1)'(rl_reg) + (PB + 1)'(2);
        kind_next = stramp_pkg::K_CRUISE;
        if (action_reg == stramp_pkg::ACT_MOVE) begin
            kind_next = stramp_pkg::K_MOVE;
        end else if (action_reg == stramp_pkg::ACT_ZERO) begin
            kind_next = stramp_pkg::K_ZERO;
        end else if (action_reg == stramp_pkg::ACT_NOP || phase_reg == stramp_pkg::PH_IDLE ||
                     steps_reg == '0) begin
            kind_next = stramp_pkg::K_NOP;
        end else if (steps_reg <= PB'(rl_reg)) begin
            kind_next = stramp_pkg::K_DECEL;
        end else if (phase_reg == stramp_pkg::PH_ACCEL && rl_reg < RL_W'(TABLE_DEPTH) &&
                     rl_plus2 <= {1'b0, steps_reg}) begin
            kind_next = stramp_pkg::K_ACCEL;
        end
    end

    assign div_needed = cur_reg > IW'(min_ivl_reg);

    // restoring divider, one quotient bit per cycle
    logic [CW-1:0] dv_eff;
    logic [CW:0]   trial;
    logic [CW:0]   trial_sub;
    logic          trial_ge;
    logic [CW-1:0] rem_next;

    always_comb begin
        dv_eff    = (divisor_reg == '0) ? CW'(1) : divisor_reg;
        trial     = {rem_reg, quo_reg[IW-1]};
        trial_sub = trial - {1'b0, dv_eff};
        trial_ge  = trial >= {1'b0, dv_eff};
        rem_next  = trial_ge ? trial_sub[CW-1:0] : trial[CW-1:0];
    end

    // scaling and difference
    logic signed [32:0] prod_ext;
    logic signed [32:0] scaled;
    logic signed [PB:0] diff_next;

    always_comb begin
        prod_ext = 33'(product_reg);
        if (prod_ext > SAT_HI) begin
            scaled = SAT_HI;
        end else if (prod_ext < SAT_LO) begin
            scaled = SAT_LO;
        end else begin
            scaled = prod_ext;
        end
        diff_next = $signed(scaled[PB:0]) - $signed({pos_reg[PB-1], pos_reg});
    end

    // acceleration interval
    logic [IW:0]   accel_raw;
    logic          accel_clamp;
    logic [IW-1:0] accel_ivl;

    always_comb begin
        accel_raw   = {1'b0, cur_reg} - {1'b0, quo_reg} - (IW + 1)'(1);
        accel_clamp = !div_needed || accel_raw[IW] || accel_raw[IW-1:0] <= IW'(min_ivl_reg);
        accel_ivl   = accel_clamp ? IW'(min_ivl_reg) : accel_raw[IW-1:0];
    end

    // ramp table
    logic [RL_W-1:0] rl_dec;
    logic [IW-1:0]   table_rdata;
    logic            table_we;

    assign rl_dec   = rl_reg - RL_W'(1);
    assign table_we = cmd.commit && kind_reg == stramp_pkg::K_ACCEL;

    stramp_ram #(
        .WIDTH (IW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (table_we),
        .waddr (rl_reg[AW-1:0]),
        .wdata (accel_ivl),
        .raddr (rl_dec[AW-1:0]),
        .rdata (table_rdata)
    );

    // commit
    logic          diff_neg;
    logic [PB:0]   diff_abs;

    always_comb begin
        diff_neg      = diff_reg[PB];
        diff_abs      = diff_neg ? -diff_reg : diff_reg;
        pos_next      = pos_reg;
        cur_next      = cur_reg;
        rl_next       = rl_reg;
        phase_next    = phase_reg;
        steps_next    = steps_reg;
        dir_next      = dir_reg;
        res_step_next = 1'b0;
        res_ivl_next  = '0;
        res_last_next = 1'b0;
        unique case (kind_reg) inside
            stramp_pkg::K_MOVE: begin
                dir_next   = !diff_neg && diff_reg != '0;
                steps_next = diff_abs[PB-1:0];
                cur_next   = start_ivl_reg;
                rl_next    = '0;
                phase_next = (diff_abs == '0) ? stramp_pkg::PH_IDLE : stramp_pkg::PH_ACCEL;
            end
            stramp_pkg::K_ZERO: begin
                pos_next   = '0;
                phase_next = stramp_pkg::PH_IDLE;
                steps_next = '0;
                rl_next    = '0;
            end
            stramp_pkg::K_NOP: begin
                if (steps_reg == '0) begin
                    phase_next = stramp_pkg::PH_IDLE;
                end
            end
            stramp_pkg::K_DECEL, stramp_pkg::K_ACCEL, stramp_pkg::K_CRUISE: begin
                if (kind_reg == stramp_pkg::K_DECEL) begin
                    phase_next   = stramp_pkg::PH_DECEL;
                    rl_next      = rl_dec;
                    res_ivl_next = table_rdata;
                end else if (kind_reg == stramp_pkg::K_ACCEL) begin
                    cur_next     = accel_ivl;
                    rl_next      = rl_reg + RL_W'(1);
                    res_ivl_next = accel_ivl;
                    if (accel_clamp) begin
                        phase_next = stramp_pkg::PH_CRUISE;
                    end
                end else begin
                    phase_next   = stramp_pkg::PH_CRUISE;
                    res_ivl_next = cur_reg;
                end
                pos_next      = dir_reg ? pos_reg + PB'(1) : pos_reg - PB'(1);
                steps_next    = steps_reg - PB'(1);
                res_step_next = 1'b1;
                if (steps_reg == PB'(1)) begin
                    phase_next    = stramp_pkg::PH_IDLE;
                    rl_next       = '0;
                    res_last_next = 1'b1;
                end
            end
            default: phase_next = phase_reg;
        endcase
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_ivl_reg <= stramp_pkg::START_INTERVAL_RST;
            min_ivl_reg   <= stramp_pkg::MIN_INTERVAL_RST;
            divisor_reg   <= stramp_pkg::RAMP_DIVISOR_RST;
            scale_reg     <= stramp_pkg::UNITS_SCALE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                stramp_pkg::REG_START_INTERVAL: start_ivl_reg <= cfg_data;
                stramp_pkg::REG_MIN_INTERVAL:   min_ivl_reg   <= cfg_data[CW-1:0];
                stramp_pkg::REG_RAMP_DIVISOR:   divisor_reg   <= cfg_data[CW-1:0];
                stramp_pkg::REG_UNITS_SCALE:    scale_reg     <= cfg_data[CW-1:0];
                default:                        start_ivl_reg <= start_ivl_reg;
            endcase
        end
    end

    // move state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            cur_reg   <= '0;
            rl_reg    <= '0;
            phase_reg <= stramp_pkg::PH_IDLE;
            steps_reg <= '0;
            dir_reg   <= 1'b0;
        end else if (cmd.commit) begin
            pos_reg   <= pos_next;
            cur_reg   <= cur_next;
            rl_reg    <= rl_next;
            phase_reg <= phase_next;
            steps_reg <= steps_next;
            dir_reg   <= dir_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= s_data.action;
            target_reg <= s_data.target;
        end
        if (cmd.decode) begin
            kind_reg    <= kind_next;
            product_reg <= target_reg * $signed({1'b0, scale_reg});
            quo_reg     <= cur_reg - IW'(min_ivl_reg);
            rem_reg     <= '0;
            cnt_reg     <= '0;
        end
        if (cmd.diff) begin
            diff_reg <= diff_next;
        end
        if (cmd.div_step) begin
            quo_reg <= {quo_reg[IW-2:0], trial_ge};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.commit) begin
            res_step_reg <= res_step_next;
            res_ivl_reg  <= res_ivl_next;
            res_last_reg <= res_last_next;
        end
    end

    // output register
    logic [31:0] pos_wide;

    assign pos_wide = 32'(pos_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg.step      <= res_step_reg;
            m_data_reg.direction <= dir_reg;
            m_data_reg.interval  <= res_ivl_reg;
            m_data_reg.position  <= pos_wide[stramp_pkg::POS_OUT_W-1:0];
            m_data_reg.busy_res  <= phase_reg != stramp_pkg::PH_IDLE;
            m_data_reg.last_step <= res_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.kind       = kind_next;
    assign status.div_needed = div_needed;
    assign status.div_last   = cnt_reg == stramp_pkg::DIV_CNT_W'(stramp_pkg::DIV_STEPS - 1);
    assign status.out_free   = !m_valid_reg || m_ready;

endmodule

// ===== design/stepper_trapezoid_ramp_top.sv =====
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_top
// Trapezoidal speed ramp generator for a stepper motor move.
// Each accepted item is decoded; move starts then take the target difference,
// deceleration steps read the ramp table, acceleration steps above the minimum
// interval run the restoring divider, and other items go straight to commit,
// followed by emit. Items are handled one at a time: a result still waiting
// in the output register holds the sequencer in emit and blocks the next
// accept. Synchronous active-low reset clears position and move state and
// restores register defaults; the ramp table is not cleared.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp_top #(
    parameter int TABLE_DEPTH   = stramp_pkg::TABLE_DEPTH,
    parameter int POSITION_BITS = stramp_pkg::POSITION_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  stramp_pkg::in_beat_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output stramp_pkg::out_beat_t m_data
);

    stramp_pkg::ctrl_cmd_t  cmd;
    stramp_pkg::dp_status_t status;

    stramp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    stramp_dp #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

// ===== verif/stepper_trapezoid_ramp_checker.sv =====
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_checker
// Watches the register port and both channels of the stepper ramp generator,
// keeps its own copy of the move profile state, predicts the result of
// every accepted beat and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp_checker
    import stramp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_beat_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_beat_t m_data,
    output int        errors,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_MAX = 2 ** (POSITION_BITS - 1) - 1;
    localparam int POS_MIN = -POS_MAX - 1;

    logic [15:0]                     start_ivl;
    logic [7:0]                      min_ivl;
    logic [7:0]                      divisor;
    logic [7:0]                      scale;
    logic signed [POSITION_BITS-1:0] pos_cnt;
    logic [15:0]                     cur_ivl;
    int                              ramp_len;
    int                              steps_left;
    phase_t                          phase;
    logic                            move_fwd;
    logic [15:0]                     ramp_mem [TABLE_DEPTH];
    out_beat_t                       due_steps [$];
    int                              err_n = 0;
    int                              pend_n = 0;

    assign errors  = err_n;
    assign pending = pend_n;

    function automatic out_beat_t advance_profile(in_beat_t beat);
        out_beat_t   res;
        int          scaled;
        int          delta;
        int          nv;
        int          dv;
        int          mn;
        logic [15:0] ivl;
        logic        stepped;
        logic        last;
        stepped = 1'b0;
        last    = 1'b0;
        ivl     = '0;
        case (beat.action)
            ACT_MOVE: begin
                scaled = int'($signed(beat.target)) * int'(scale);
                if (scaled > POS_MAX) scaled = POS_MAX;
                if (scaled < POS_MIN) scaled = POS_MIN;
                delta      = scaled - int'(pos_cnt);
                move_fwd   = (delta > 0);
                steps_left = (delta > 0) ? delta : -delta;
                cur_ivl    = start_ivl;
                ramp_len   = 0;
                phase      = (steps_left != 0) ? PH_ACCEL : PH_IDLE;
            end
            ACT_ZERO: begin
                pos_cnt    = '0;
                phase      = PH_IDLE;
                steps_left = 0;
                ramp_len   = 0;
            end
            default: begin
                if (beat.action == ACT_NOP || phase == PH_IDLE || steps_left == 0) begin
                    if (steps_left == 0) phase = PH_IDLE;
                end else begin
                    if (steps_left <= ramp_len) begin
                        phase    = PH_DECEL;
                        ramp_len = ramp_len - 1;
                        ivl      = ramp_mem[ramp_len];
                    end else if (phase == PH_ACCEL && ramp_len < TABLE_DEPTH &&
                                 ramp_len + 2 <= steps_left) begin
                        mn = int'(min_ivl);
                        dv = (divisor != 0) ? int'(divisor) : 1;
                        nv = int'(cur_ivl) - (int'(cur_ivl) - mn) / dv - 1;
                        if (nv <= mn) begin
                            nv    = mn;
                            phase = PH_CRUISE;
                        end
                        cur_ivl            = nv[15:0];
                        ramp_mem[ramp_len] = nv[15:0];
                        ramp_len           = ramp_len + 1;
                        ivl                = cur_ivl;
                    end else begin
                        phase = PH_CRUISE;
                        ivl   = cur_ivl;
                    end
                    pos_cnt    = move_fwd ? pos_cnt + 1'b1 : pos_cnt - 1'b1;
                    steps_left = steps_left - 1;
                    if (steps_left == 0) begin
                        phase    = PH_IDLE;
                        ramp_len = 0;
                        last     = 1'b1;
                    end
                    stepped = 1'b1;
                end
            end
        endcase
        res.step      = stepped;
        res.direction = move_fwd;
        res.interval  = ivl;
        res.position  = pos_cnt;
        res.busy_res  = (phase != PH_IDLE);
        res.last_step = last;
        return res;
    endfunction

    task automatic check_field(input string fname, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            err_n++;
        end
    endtask

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            start_ivl  = START_INTERVAL_RST;
            min_ivl    = MIN_INTERVAL_RST;
            divisor    = RAMP_DIVISOR_RST;
            scale      = UNITS_SCALE_RST;
            pos_cnt    = '0;
            cur_ivl    = '0;
            ramp_len   = 0;
            steps_left = 0;
            phase      = PH_IDLE;
            move_fwd   = 1'b0;
            due_steps.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_START_INTERVAL: start_ivl = cfg_data;
                    REG_MIN_INTERVAL:   min_ivl   = cfg_data[7:0];
                    REG_RAMP_DIVISOR:   divisor   = cfg_data[7:0];
                    REG_UNITS_SCALE:    scale     = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (due_steps.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %p",
                             $time, m_data);
                    err_n++;
                end else begin
                    want = due_steps.pop_front();
                    check_field("step", want.step, m_data.step);
                    check_field("direction", want.direction, m_data.direction);
                    check_field("interval", want.interval, m_data.interval);
                    check_field("position", want.position, m_data.position);
                    check_field("busy_res", want.busy_res, m_data.busy_res);
                    check_field("last_step", want.last_step, m_data.last_step);
                end
            end
            if (s_valid && s_ready) due_steps.push_back(advance_profile(s_data));
        end
        pend_n <= due_steps.size();
    end

endmodule

// ===== verif/stepper_trapezoid_ramp_top_tb.sv =====
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_top_tb
// Drives move, advance, zero and no-op beats into the stepper ramp generator
// under several register settings and pacing modes, including a long
// receiver stall, and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stramp_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_beat_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_beat_t   m_data;

    int mismatches;
    int in_flight;
    int send_idle_pct = 33;
    int recv_idle_pct = 69;
    int hold_ask = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int pos_est = 0;
    int goal = 0;
    int cur_scale = UNITS_SCALE_RST;
    int issued = 0;

    always #5 aclk = ~aclk;

    stepper_trapezoid_ramp_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    stepper_trapezoid_ramp_checker checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .errors    (mismatches),
        .pending   (in_flight)
    );

    always @(posedge aclk) begin
        if (hold_seen != hold_ask) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic offer(input logic [1:0] act, input logic [15:0] tgt);
        in_beat_t beat;
        beat.action = act;
        beat.target = tgt;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        case (act)
            ACT_MOVE: goal = int'($signed(tgt)) * cur_scale;
            ACT_ZERO: begin
                pos_est = 0;
                goal    = 0;
            end
            ACT_STEP: begin
                if (pos_est < goal) pos_est++;
                else if (pos_est > goal) pos_est--;
            end
            default: ;
        endcase
        if (act != ACT_NOP) issued++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    task automatic program_regs(input logic [15:0] start_v, input logic [15:0] min_v,
                                input logic [15:0] div_v, input logic [15:0] scale_v);
        drain();
        write_reg(REG_START_INTERVAL, start_v);
        write_reg(REG_MIN_INTERVAL, min_v);
        write_reg(REG_RAMP_DIVISOR, div_v);
        write_reg(REG_UNITS_SCALE, scale_v);
        cfg_wr_en <= 1'b0;
        cur_scale = int'(scale_v[7:0]);
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // well-formed move: target near the current position, then advance it out
    task automatic move_episode();
        int span;
        int units;
        int gap;
        int n;
        span  = (cur_scale >= 48) ? 1 : 48 / cur_scale;
        units = pos_est / cur_scale + int'($urandom_range(0, 2 * span)) - span;
        if (units > 32767) units = 32767;
        if (units < -32768) units = -32768;
        offer(ACT_MOVE, units[15:0]);
        gap = (goal > pos_est) ? goal - pos_est : pos_est - goal;
        if ($urandom_range(0, 9) == 0) n = int'($urandom_range(0, gap));
        else n = gap + int'($urandom_range(0, 2));
        repeat (n) offer(ACT_STEP, 16'($urandom));
    endtask

    task automatic run_phase(input int budget);
        int k;
        issued = 0;
        while (issued < budget) begin
            k = int'($urandom_range(0, 99));
            if (k < 72) begin
                move_episode();
            end else if (k < 80) begin
                offer(ACT_ZERO, 16'($urandom));
            end else if (k < 86) begin
                offer(ACT_NOP, 16'($urandom));
            end else if (k < 94) begin
                offer(ACT_MOVE, 16'($urandom));
                repeat ($urandom_range(0, 3)) offer(ACT_STEP, 16'($urandom));
                if ($urandom_range(0, 1) == 1) offer(ACT_ZERO, 16'($urandom));
            end else begin
                offer(ACT_STEP, 16'($urandom));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        offer(ACT_STEP, 16'h7FFF);
        offer(ACT_NOP, 16'h8000);
        offer(ACT_MOVE, 16'h0000);
        offer(ACT_MOVE, 16'd3);
        repeat (6) offer(ACT_STEP, 16'h0000);
        offer(ACT_NOP, 16'hFFFF);
        offer(ACT_MOVE, 16'hFFFF);
        repeat (2) offer(ACT_STEP, 16'hFFFF);
        offer(ACT_ZERO, 16'h0000);
        offer(ACT_MOVE, 16'h7FFF);
        offer(ACT_MOVE, 16'h8000);
        offer(ACT_STEP, 16'h5555);
        offer(ACT_ZERO, 16'hAAAA);
        offer(ACT_STEP, 16'h0000);

        run_phase(90);

        // slow ramp that fills the whole table before cruising
        program_regs(16'd65535, 16'd1, 16'd255, 16'd1);
        offer(ACT_ZERO, 16'h0000);
        offer(ACT_MOVE, 16'd300);
        repeat (300) offer(ACT_STEP, 16'($urandom));
        run_phase(70);

        set_idle(69, 33);
        program_regs(16'd1, 16'd255, 16'd1, 16'd255);
        run_phase(70);
        program_regs(16'd40, 16'd40, 16'd255, 16'd7);
        run_phase(80);

        set_idle(0, 0);
        program_regs(16'd300, 16'd10, 16'd3, 16'd3);
        hold_ask <= hold_ask + 1;
        run_phase(100);
        program_regs(16'($urandom_range(1, 65535)),
                     {8'($urandom), 8'($urandom_range(1, 255))},
                     {8'($urandom), 8'($urandom_range(1, 255))},
                     {8'($urandom), 8'($urandom_range(1, 16))});
        run_phase(80);

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && in_flight == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
